/* rtl/lpl_pkg.sv */
// Shared types and constants for the lookahead peak limiter.
// No dependencies; imported by every module of the block.
package lpl_pkg;

    localparam int SAMPLE_W   = 24;      // Q3.20 signed audio sample
    localparam int MAG_W      = 23;      // sample magnitude, saturated
    localparam int GAIN_W     = 21;      // Q1.20 unsigned gain
    localparam int FRAC_W     = 20;      // fractional bits of a gain
    localparam int QUOT_W     = 20;      // divider quotient, always below unity
    localparam int CEIL_W     = 21;
    localparam int COEF_W     = 16;
    localparam int LEN_CFG_W  = 10;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 2;

    localparam logic [GAIN_W-1:0] UNITY_GAIN   = GAIN_W'(1048576);
    localparam logic [CEIL_W-1:0] CEIL_RESET   = CEIL_W'(1027604);
    localparam logic [COEF_W-1:0] COEF_RESET   = '0;
    localparam int                MAX_DELAY_DEF = 512;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CEILING = 2'd0,
        REG_RELEASE = 2'd1,
        REG_DELAY   = 2'd2
    } t_reg_idx;

endpackage

/* rtl/lookahead_peak_limiter.sv */
// Lookahead peak limiter: top level with sequencer, envelope and output scaling.
// Depends on lpl_pkg, lpl_div (gain divider) and lpl_ring (delay memory).
//
// Usage: each input transaction carries one signed Q3.20 sample on
// i_sample_in (i_in_valid / o_in_ready) and produces exactly one output
// transaction on o_sample_out (o_out_valid / i_out_ready). The sample goes
// into a delay ring of delay_length entries; the entry that has waited
// delay_length-1 samples is scaled by a gain envelope and sent out. While
// the ring has not yet filled since the last delay_length write, the output
// is zero.
// The block works on one sample at a time. A sample whose magnitude stays at
// or below the ceiling passes through the read, divide, two envelope, scale
// and output steps, and the next sample is accepted once it has left the
// output step; one above the ceiling also waits in the divide step for the
// 20-step serial divider that forms ceiling/magnitude. The delay ring is a
// single-port-write, single-port-read memory with registered read data.
// The finished result sits in an output register, so a stalled receiver holds
// only that register: the next sample is accepted and processed, and waits
// in the last step until the output register is free.
// Reset (synchronous, active low) restores the register defaults, unity gain,
// an empty ring and an empty output. Configuration writes are taken on any
// cycle with i_cfg_we high and are meant for idle periods; writing
// delay_length restarts ring filling.
module lookahead_peak_limiter #(
    parameter int MAX_DELAY = lpl_pkg::MAX_DELAY_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lpl_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [lpl_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0]    i_sample_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [lpl_pkg::SAMPLE_W-1:0]    o_sample_out
);
    import lpl_pkg::*;

    localparam int AW     = $clog2(MAX_DELAY);
    localparam int LW     = $clog2(MAX_DELAY + 1);
    localparam int PROD_W = GAIN_W + COEF_W + 2;
    localparam int SCL_W  = SAMPLE_W + GAIN_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_ENV1,
        S_ENV2,
        S_SCALE,
        S_OUT
    } t_state;

    // Control and configuration registers.
    t_state                     r_state, n_state;
    logic [CEIL_W-1:0]          r_ceil;
    logic [COEF_W-1:0]          r_coef;
    logic [LW-1:0]              r_len;
    logic [AW-1:0]              r_wp, n_wp;
    logic [LW-1:0]              r_fill, n_fill;
    logic [GAIN_W-1:0]          r_env, n_env;
    logic                       r_out_valid;

    // Per-sample working registers.
    logic [AW-1:0]              r_rd;
    logic                       r_use_data;
    logic                       r_need_div;
    logic [GAIN_W-1:0]          r_target;
    logic                       r_drop;
    logic signed [PROD_W-1:0]   r_rel;
    logic signed [SCL_W-1:0]    r_scaled;
    logic signed [SAMPLE_W-1:0] r_out;

    logic                       in_acc;
    logic                       out_load;
    logic [MAG_W-1:0]           mag;
    logic                       need_div;
    logic [LW-1:0]              wp_lw;
    logic [AW-1:0]              wp_eff;
    logic [LW-1:0]              rd_lw;
    logic [AW-1:0]              rd_next;
    logic                       div_busy;
    logic [QUOT_W-1:0]          div_quot;
    logic [SAMPLE_W-1:0]        ring_rdata;
    logic signed [SAMPLE_W-1:0] delayed;
    logic signed [GAIN_W:0]     env_diff;
    logic signed [PROD_W-1:0]   rel_prod;
    logic signed [GAIN_W+1:0]   env_rel;
    logic [LEN_CFG_W-1:0]       len_raw;
    logic [LW-1:0]              len_clamp;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Magnitude with the most negative code saturating to the largest positive.
    always_comb begin
        if (i_sample_in[SAMPLE_W-1]) begin
            if (i_sample_in == {1'b1, {(SAMPLE_W-1){1'b0}}}) begin
                mag = '1;
            end else begin
                mag = MAG_W'(-i_sample_in);
            end
        end else begin
            mag = MAG_W'(i_sample_in);
        end
    end

    assign need_div = (mag > MAG_W'(r_ceil));

    // Ring pointer arithmetic: write at the current slot, read the next one.
    always_comb begin
        wp_lw   = LW'(r_wp);
        wp_eff  = (wp_lw >= r_len) ? '0 : r_wp;
        rd_lw   = LW'(wp_eff) + LW'(1);
        rd_next = (rd_lw >= r_len) ? '0 : rd_lw[AW-1:0];
        n_fill  = (r_fill < r_len) ? (r_fill + LW'(1)) : r_fill;
        n_wp    = rd_next;
    end

    // Release step: env moves back toward a higher target by a fraction of
    // the gap; the product is floor-shifted so it rounds toward minus infinity.
    assign env_diff = signed'({1'b0, r_env}) - signed'({1'b0, r_target});
    assign rel_prod = signed'({1'b0, r_coef}) * env_diff;
    assign env_rel  = signed'({2'b00, r_target}) + (GAIN_W+2)'(r_rel >>> COEF_W);

    always_comb begin
        n_env = r_env;
        if (r_state == S_ENV2) begin
            n_env = r_drop ? r_target : env_rel[GAIN_W-1:0];
        end
    end

    assign delayed  = r_use_data ? signed'(ring_rdata) : '0;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_READ;
            S_READ:  n_state = S_DIV;
            S_DIV:   if (!r_need_div || !div_busy) n_state = S_ENV1;
            S_ENV1:  n_state = S_ENV2;
            S_ENV2:  n_state = S_SCALE;
            S_SCALE: n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Delay length is clamped into 1..MAX_DELAY.
    always_comb begin
        len_raw = i_cfg_data[LEN_CFG_W-1:0];
        if (len_raw == '0) begin
            len_clamp = LW'(1);
        end else if (32'(len_raw) > 32'(MAX_DELAY)) begin
            len_clamp = LW'(MAX_DELAY);
        end else begin
            len_clamp = LW'(len_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ceil      <= CEIL_RESET;
            r_coef      <= COEF_RESET;
            r_len       <= LW'(1);
            r_wp        <= '0;
            r_fill      <= '0;
            r_env       <= UNITY_GAIN;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_env   <= n_env;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_wp   <= n_wp;
                r_fill <= n_fill;
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_CEILING: r_ceil <= i_cfg_data[CEIL_W-1:0];
                    REG_RELEASE: r_coef <= i_cfg_data[COEF_W-1:0];
                    REG_DELAY: begin
                        r_len  <= len_clamp;
                        r_wp   <= '0;
                        r_fill <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd       <= rd_next;
            r_use_data <= (n_fill >= r_len);
            r_need_div <= need_div;
        end
        if (r_state == S_DIV) begin
            r_target <= r_need_div ? {1'b0, div_quot} : UNITY_GAIN;
        end
        if (r_state == S_ENV1) begin
            r_rel  <= rel_prod;
            r_drop <= (r_target < r_env);
        end
        if (r_state == S_SCALE) begin
            r_scaled <= delayed * signed'({1'b0, r_env});
        end
        if (out_load) begin
            r_out <= r_scaled[SAMPLE_W+FRAC_W-1:FRAC_W];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

    lpl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc && need_div),
        .i_num   (r_ceil),
        .i_den   (mag),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // The read is issued in the cycle after the write, so a ring of length one
    // returns the sample just written.
    lpl_ring #(
        .DEPTH (MAX_DELAY),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (wp_eff),
        .i_wdata (i_sample_in),
        .i_re    (r_state == S_READ),
        .i_raddr (r_rd),
        .o_rdata (ring_rdata)
    );

`ifndef NO_ASSERTIONS
    a_env_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= UNITY_GAIN)
        else $error("gain envelope above unity");

    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_wp) < r_len)
        else $error("write position outside ring length");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_len)
        else $error("fill count above ring length");

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ENV1) && r_need_div |-> !div_busy)
        else $error("target gain taken before the division finished");
`endif

endmodule

/* rtl/lpl_div.sv */
// Restoring serial divider: floor(num * 2^20 / den) for num < den.
// Depends on lpl_pkg. One quotient bit per clock cycle.
module lpl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lpl_pkg::CEIL_W-1:0]  i_num,
    input  logic [lpl_pkg::MAG_W-1:0]   i_den,
    output logic                        o_busy,
    output logic [lpl_pkg::QUOT_W-1:0]  o_quot
);
    import lpl_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic [MAG_W:0]        r_rem, n_rem;
    logic [MAG_W-1:0]      r_den;
    logic [QUOT_W-1:0]     r_quot, n_quot;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_busy, n_busy;
    logic [MAG_W:0]        rem_sh;

    // The partial remainder stays below den, so doubling it fits one extra bit.
    always_comb begin
        rem_sh = {r_rem[MAG_W-1:0], 1'b0};
        n_rem  = r_rem;
        n_quot = r_quot;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = (MAG_W+1)'(i_num);
            n_cnt  = CNT_W'(QUOT_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem  = rem_sh - {1'b0, r_den};
                n_quot = {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_quot = {r_quot[QUOT_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - CNT_W'(1);
            n_busy = (r_cnt != CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

/* rtl/lpl_ring.sv */
// Delay ring storage: one write port and one read port, registered read data.
// Depends on lpl_pkg for the sample width.
module lpl_ring #(
    parameter int DEPTH = lpl_pkg::MAX_DELAY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [lpl_pkg::SAMPLE_W-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [lpl_pkg::SAMPLE_W-1:0]  o_rdata
);
    import lpl_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds between read strobes.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
